// ----- rtl/core/kroot_pkg.sv -----
package kroot_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned DEG_W  = 8;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DEG_W-1:0]  degree;
  } kr_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] root_value;
    logic [DATA_W-1:0] leftover;
    logic              invalid;
  } kr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_ACC,
    ST_FINISH
  } state_e;

  // how the result register is filled at the end of a transaction
  typedef enum logic [2:0] {
    RES_INVALID,
    RES_ZERO,
    RES_IDENT,
    RES_ONE,
    RES_SEARCH
  } res_mode_e;

  typedef struct packed {
    logic      load;
    logic      init;
    logic      mul;
    logic      acc;
    logic      next;
    logic      keep;
    logic      finish;
    res_mode_e mode;
  } kr_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic n_zero;
    logic k_one;
    logic root_one;
    logic c_over;
    logic prod_over;
    logic pow_done;
    logic bit_zero;
  } kr_stat_t;

endpackage

// ----- rtl/core/integer_kth_root_remainder.sv -----
// Integer k-th root with remainder.
// Command channel: present req_i (value n, degree k) with start_i high; the
// transaction is taken at the clock edge where start_i is high and busy_o is
// low. Bits of value at or above WORD_BITS are ignored.
// Result channel: res_o (root_value, leftover, invalid) is valid for exactly
// one cycle while done_o is high. The receiver cannot stall; res_o keeps
// its value only until the next result is written. busy_o drops on the
// cycle done_o rises, so a new command may be issued while a result is shown.
// Special cases (k = 0, n = 0, k = 1, 2^k > n or k >= WORD_BITS) are
// settled in ST_CHECK, and done_o follows from the registered finish
// command. Otherwise the root is found bit by bit over (WORD_BITS+1)/2
// candidates; each candidate is tested in ST_TEST, and each multiply of
// its power chain (at most k-1 multiplies, cut short once the power
// exceeds n) passes through ST_ACC back to ST_TEST. The search ends in
// ST_FINISH.
// The search time is set by the single shared 2-slice multiplier loop.
// Reset: asynchronous, active low; returns the controller to idle and
// clears done_o. No transaction depends on state left by an earlier one.
module integer_kth_root_remainder #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  kroot_pkg::kr_in_t  req_i,
  output logic               busy_o,
  output logic               done_o,
  output kroot_pkg::kr_out_t res_o
);

  // command and status between sequencer and datapath
  kroot_pkg::kr_cmd_t  cmd;
  kroot_pkg::kr_stat_t stat;

  // sequencer: special-case dispatch, candidate loop, power chain
  kroot_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // datapath: operand, candidate and power registers, split multiplier,
  // overflow compare and result register
  kroot_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o)
  );

endmodule

// ----- rtl/core/kroot_ctrl.sv -----
module kroot_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  kroot_pkg::kr_stat_t stat_i,
  output kroot_pkg::kr_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);

  kroot_pkg::state_e state_q, state_d;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kroot_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.init   = 1'b0;
    cmd_o.mul    = 1'b0;
    cmd_o.acc    = 1'b0;
    cmd_o.next   = 1'b0;
    cmd_o.keep   = 1'b0;
    cmd_o.finish = 1'b0;
    cmd_o.mode   = kroot_pkg::RES_SEARCH;
    case (state_q)
      kroot_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = kroot_pkg::ST_CHECK;
        end
      end
      kroot_pkg::ST_CHECK: begin
        if (stat_i.k_zero) begin
          cmd_o.finish = 1'b1;
          cmd_o.mode   = kroot_pkg::RES_INVALID;
          state_d      = kroot_pkg::ST_IDLE;
        end else if (stat_i.n_zero) begin
          cmd_o.finish = 1'b1;
          cmd_o.mode   = kroot_pkg::RES_ZERO;
          state_d      = kroot_pkg::ST_IDLE;
        end else if (stat_i.k_one) begin
          cmd_o.finish = 1'b1;
          cmd_o.mode   = kroot_pkg::RES_IDENT;
          state_d      = kroot_pkg::ST_IDLE;
        end else if (stat_i.root_one) begin
          cmd_o.finish = 1'b1;
          cmd_o.mode   = kroot_pkg::RES_ONE;
          state_d      = kroot_pkg::ST_IDLE;
        end else begin
          cmd_o.init = 1'b1;
          state_d    = kroot_pkg::ST_TEST;
        end
      end
      kroot_pkg::ST_TEST: begin
        if (stat_i.c_over || stat_i.pow_done) begin
          cmd_o.next = 1'b1;
          cmd_o.keep = !stat_i.c_over;
          state_d    = stat_i.bit_zero ? kroot_pkg::ST_FINISH : kroot_pkg::ST_TEST;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = kroot_pkg::ST_ACC;
        end
      end
      kroot_pkg::ST_ACC: begin
        if (stat_i.prod_over) begin
          cmd_o.next = 1'b1;
          state_d    = stat_i.bit_zero ? kroot_pkg::ST_FINISH : kroot_pkg::ST_TEST;
        end else begin
          cmd_o.acc = 1'b1;
          state_d   = kroot_pkg::ST_TEST;
        end
      end
      kroot_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        cmd_o.mode   = kroot_pkg::RES_SEARCH;
        state_d      = kroot_pkg::ST_IDLE;
      end
      default: begin
        state_d = kroot_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != kroot_pkg::ST_IDLE);
  assign done_o = done_q;

endmodule

// ----- rtl/core/kroot_dp.sv -----
module kroot_dp #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                clk_i,
  input  kroot_pkg::kr_in_t   req_i,
  input  kroot_pkg::kr_cmd_t  cmd_i,
  output kroot_pkg::kr_stat_t stat_o,
  output kroot_pkg::kr_out_t  res_o
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned CW    = (WORD_BITS + 1) / 2;  // root width
  localparam int unsigned HW    = W - CW;               // upper slice of the power
  localparam int unsigned PW    = W + CW;               // full product width
  localparam int unsigned PLW   = 2 * CW;
  localparam int unsigned PHW   = HW + CW;
  localparam int unsigned BIT_W = (CW > 1) ? $clog2(CW) : 1;
  localparam int unsigned DW    = kroot_pkg::DATA_W;
  localparam int unsigned KW    = kroot_pkg::DEG_W;

  logic [W-1:0]     n_q, p_q, best_q;
  logic [KW-1:0]    k_q, cnt_q;
  logic [CW-1:0]    r_q, c_q;
  logic [BIT_W-1:0] bit_q;
  logic [PLW-1:0]   pl_q;
  logic [PHW-1:0]   ph_q;
  kroot_pkg::kr_out_t res_q;

  logic [PW-1:0]    sum;
  logic [CW-1:0]    r_nx, c_nx, c_init;
  logic [BIT_W-1:0] bit_m1;

  // p * c rebuilt from the two registered partial products
  assign sum    = {ph_q, {CW{1'b0}}} + PW'(pl_q);
  assign r_nx   = cmd_i.keep ? c_q : r_q;
  assign bit_m1 = bit_q - 1'b1;
  assign c_nx   = r_nx | (CW'(1) << bit_m1);
  assign c_init = CW'(1) << BIT_W'(CW - 1);

  assign stat_o.k_zero    = (k_q == '0);
  assign stat_o.n_zero    = (n_q == '0);
  assign stat_o.k_one     = (k_q == KW'(1));
  assign stat_o.root_one  = (k_q >= KW'(W)) || ((n_q >> k_q) == '0);
  assign stat_o.c_over    = (W'(c_q) > n_q);
  assign stat_o.prod_over = (sum > PW'(n_q));
  assign stat_o.pow_done  = (cnt_q == k_q);
  assign stat_o.bit_zero  = (bit_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= req_i.value[W-1:0];
      k_q <= req_i.degree;
    end
    if (cmd_i.init) begin
      r_q    <= '0;
      best_q <= '0;
      bit_q  <= BIT_W'(CW - 1);
      c_q    <= c_init;
      p_q    <= W'(c_init);
      cnt_q  <= KW'(1);
    end
    if (cmd_i.mul) begin
      pl_q <= PLW'(p_q[CW-1:0]) * PLW'(c_q);
      ph_q <= PHW'(p_q[W-1:CW]) * PHW'(c_q);
    end
    if (cmd_i.acc) begin
      p_q   <= sum[W-1:0];
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.next) begin
      if (cmd_i.keep) begin
        r_q    <= c_q;
        best_q <= p_q;
      end
      if (bit_q != '0) begin
        bit_q <= bit_m1;
        c_q   <= c_nx;
        p_q   <= W'(c_nx);
        cnt_q <= KW'(1);
      end
    end
    if (cmd_i.finish) begin
      case (cmd_i.mode)
        kroot_pkg::RES_INVALID: begin
          res_q.root_value <= '0;
          res_q.leftover   <= '0;
          res_q.invalid    <= 1'b1;
        end
        kroot_pkg::RES_IDENT: begin
          res_q.root_value <= DW'(n_q);
          res_q.leftover   <= '0;
          res_q.invalid    <= 1'b0;
        end
        kroot_pkg::RES_ONE: begin
          res_q.root_value <= DW'(1);
          res_q.leftover   <= DW'(n_q - W'(1));
          res_q.invalid    <= 1'b0;
        end
        kroot_pkg::RES_SEARCH: begin
          res_q.root_value <= DW'(r_q);
          res_q.leftover   <= DW'(n_q - best_q);
          res_q.invalid    <= 1'b0;
        end
        default: begin
          res_q.root_value <= '0;
          res_q.leftover   <= '0;
          res_q.invalid    <= 1'b0;
        end
      endcase
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/core/kroot_sva.sv -----
module kroot_sva (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input kroot_pkg::kr_in_t  req_i,
  input logic               busy_o,
  input logic               done_o,
  input kroot_pkg::kr_out_t res_o
);

  // an accepted transaction makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted command");

  // a result is only shown once the block is idle again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // never two results back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("consecutive result strobes");

  // invalid degree gives all-zero results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.invalid) |-> (res_o.root_value == '0 && res_o.leftover == '0))
    else $error("invalid result with non-zero payload");

  // a zero degree command yields an invalid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.degree == '0) |-> ##2 (done_o && res_o.invalid))
    else $error("zero degree not flagged invalid");

endmodule

bind integer_kth_root_remainder kroot_sva u_kroot_sva (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .req_i   (req_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
